/* hdl/ftps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Frame time probe package
// Shared widths, fixed-point constants and sequencer state type.
// ---------------------------------------------------------------------------
package ftps_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned FRAMES_W = 32;
   localparam int unsigned SUM_W    = 39;
   localparam int unsigned FPT_W    = 48;
   localparam int unsigned CNT_W    = 7;
   localparam int unsigned ACC_W    = 49;
   localparam int unsigned PROD_W   = 64;

   localparam logic [FPT_W-1:0]    FPT_RESET    = 48'd416582966;
   localparam logic [TIME_W-1:0]   EMA_OLD_W    = 32'd62915;
   localparam logic [TIME_W-1:0]   EMA_NEW_W    = 32'd2621;
   localparam logic [ACC_W-1:0]    EMA_ROUND    = 49'd32768;
   localparam logic [CNT_W-1:0]    WARMUP_STOPS = 7'd100;
   localparam logic [FRAMES_W-1:0] FRAMES_SAT   = 32'hFFFF_FFFF;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STOP  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SAT,
      ST_EMA_NEW,
      ST_EMA_OLD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              mul_en;
      logic [TIME_W-1:0] op_a;
      logic [TIME_W-1:0] op_b;
   } mul_ctl_type;

endpackage
`default_nettype wire

/* hdl/ftps_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Frame time probe channels
// Valid/ready channels for probe events, statistics and register writes.
// ---------------------------------------------------------------------------
interface ftps_req_bus;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [ftps_pkg::TIME_W-1:0]  time_low;

   modport source (output valid, output kind, output time_low, input ready);
   modport sink   (input valid, input kind, input time_low, output ready);
endinterface

interface ftps_rsp_bus;
   logic                          valid;
   logic                          ready;
   logic [ftps_pkg::FRAMES_W-1:0] last_frames;
   logic [ftps_pkg::FRAMES_W-1:0] avg_frames;
   logic [ftps_pkg::FRAMES_W-1:0] max_frames;
   logic [ftps_pkg::SUM_W-1:0]    window_sum;

   modport source (output valid, output last_frames, output avg_frames,
                   output max_frames, output window_sum, input ready);
   modport sink   (input valid, input last_frames, input avg_frames,
                   input max_frames, input window_sum, output ready);
endinterface

interface ftps_csr_bus;
   logic                        valid;
   logic                        ready;
   logic [ftps_pkg::FPT_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/frame_time_probe_stats.sv */
`timescale 1ns / 1ps
`default_nettype none
// A stop steps the sequencer through MUL_LO, MUL_HI, SAT, EMA_NEW, EMA_OLD and FINISH;
// a start records its stamp. One start per cycle is taken while no stop is in flight;
// the single 32x32 multiplier is used four times per stop (two conversion partial
// products, two average terms). Input is not ready while a stop is in flight; a
// finished result may wait in the output register while the next event is taken.
// Reset (synchronous, active high) clears all statistics and restores frames_per_tick.
// ---------------------------------------------------------------------------
// Frame time probe statistics
// Elapsed-time probe: frames, exponential average, warm-up maximum, window sum.
// ---------------------------------------------------------------------------
module frame_time_probe_stats #(
   parameter int unsigned WINDOW_LEN = 100
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ftps_req_bus.sink        req_bus,
   ftps_rsp_bus.source      rsp_bus,
   ftps_csr_bus.sink        csr_bus
);

   localparam int unsigned POS_W = $clog2(WINDOW_LEN);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

   ftps_pkg::state_type state_ff, state_in;
   ftps_pkg::mul_ctl_type mul_ctl;

   logic [ftps_pkg::FPT_W-1:0]    fpt_ff;
   logic [ftps_pkg::TIME_W-1:0]   start_stamp_ff;
   logic [ftps_pkg::TIME_W-1:0]   ticks_ff;
   logic [ftps_pkg::PROD_W-1:0]   prod_ff;
   logic [ftps_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [ftps_pkg::FRAMES_W-1:0] frames_ff;
   logic [ftps_pkg::FRAMES_W-1:0] ema_ff, ema_in;
   logic [ftps_pkg::FRAMES_W-1:0] max_ff, max_in;
   logic [ftps_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [ftps_pkg::CNT_W-1:0]    stop_count_ff;
   logic [POS_W-1:0]              ring_pos_ff;
   logic                          wrapped_ff;
   logic [ftps_pkg::FRAMES_W-1:0] ring_mem [WINDOW_LEN];
   logic [ftps_pkg::FRAMES_W-1:0] ring_rd_ff;
   logic                          rsp_valid_ff;
   logic [ftps_pkg::FRAMES_W-1:0] rsp_last_ff, rsp_avg_ff, rsp_max_ff;
   logic [ftps_pkg::SUM_W-1:0]    rsp_sum_ff;

   logic                          req_xfer;
   logic                          out_free;
   logic                          finish_go;
   logic [ftps_pkg::ACC_W-1:0]    conv_sum;
   logic [ftps_pkg::ACC_W-1:0]    ema_sum;
   logic [ftps_pkg::FRAMES_W-1:0] frames_in;
   logic [ftps_pkg::FRAMES_W-1:0] ring_old;

   assign req_bus.ready = !reset && (state_ff == ftps_pkg::ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = !reset;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign finish_go     = (state_ff == ftps_pkg::ST_FINISH) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ftps_pkg::ST_IDLE: begin
            if (req_xfer && req_bus.kind == ftps_pkg::KIND_STOP) begin
               state_in = ftps_pkg::ST_MUL_LO;
            end
         end
         ftps_pkg::ST_MUL_LO:  state_in = ftps_pkg::ST_MUL_HI;
         ftps_pkg::ST_MUL_HI:  state_in = ftps_pkg::ST_SAT;
         ftps_pkg::ST_SAT:     state_in = ftps_pkg::ST_EMA_NEW;
         ftps_pkg::ST_EMA_NEW: state_in = ftps_pkg::ST_EMA_OLD;
         ftps_pkg::ST_EMA_OLD: state_in = ftps_pkg::ST_FINISH;
         ftps_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = ftps_pkg::ST_IDLE;
            end
         end
         default: state_in = ftps_pkg::ST_IDLE;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_ctl = '0;
      unique case (state_ff)
         ftps_pkg::ST_MUL_LO: begin
            mul_ctl.mul_en = 1'b1;
            mul_ctl.op_a   = ticks_ff;
            mul_ctl.op_b   = fpt_ff[31:0];
         end
         ftps_pkg::ST_MUL_HI: begin
            mul_ctl.mul_en = 1'b1;
            mul_ctl.op_a   = ticks_ff;
            mul_ctl.op_b   = {16'd0, fpt_ff[47:32]};
         end
         ftps_pkg::ST_EMA_NEW: begin
            mul_ctl.mul_en = 1'b1;
            mul_ctl.op_a   = frames_ff;
            mul_ctl.op_b   = ftps_pkg::EMA_NEW_W;
         end
         ftps_pkg::ST_EMA_OLD: begin
            mul_ctl.mul_en = 1'b1;
            mul_ctl.op_a   = ema_ff;
            mul_ctl.op_b   = ftps_pkg::EMA_OLD_W;
         end
         ftps_pkg::ST_IDLE, ftps_pkg::ST_SAT, ftps_pkg::ST_FINISH: begin
            mul_ctl = '0;
         end
         default: mul_ctl = '0;
      endcase
   end

   // datapath
   always_comb begin
      conv_sum  = acc_ff + prod_ff[ftps_pkg::ACC_W-1:0];
      frames_in = (conv_sum[48:32] != 17'd0) ? ftps_pkg::FRAMES_SAT : conv_sum[31:0];

      acc_in = acc_ff;
      if (state_ff == ftps_pkg::ST_MUL_HI) begin
         acc_in = {17'd0, prod_ff[63:32]};
      end else if (state_ff == ftps_pkg::ST_EMA_OLD) begin
         acc_in = prod_ff[ftps_pkg::ACC_W-1:0] + ftps_pkg::EMA_ROUND;
      end

      // weights sum to one, so the average stays inside 32 bits
      ema_sum = acc_ff + prod_ff[ftps_pkg::ACC_W-1:0];
      ema_in  = ema_sum[47:16];

      max_in = max_ff;
      if (stop_count_ff > ftps_pkg::WARMUP_STOPS && max_ff < frames_ff) begin
         max_in = frames_ff;
      end

      // unwritten ring entries read as zero until the first wrap
      ring_old = wrapped_ff ? ring_rd_ff : '0;
      sum_in   = sum_ff - {7'd0, ring_old} + {7'd0, frames_ff};
   end

   always_ff @(posedge clock) begin
      if (mul_ctl.mul_en) begin
         prod_ff <= mul_ctl.op_a * mul_ctl.op_b;
      end
      acc_ff <= acc_in;
      if (state_ff == ftps_pkg::ST_SAT) begin
         frames_ff <= frames_in;
      end
      if (req_xfer) begin
         ticks_ff <= req_bus.time_low - start_stamp_ff;
      end
      if (finish_go) begin
         rsp_last_ff <= frames_ff;
         rsp_avg_ff  <= ema_in;
         rsp_max_ff  <= max_in;
         rsp_sum_ff  <= sum_in;
      end
   end

   // history ring
   always_ff @(posedge clock) begin
      if (finish_go) begin
         ring_mem[ring_pos_ff] <= frames_ff;
      end
      ring_rd_ff <= ring_mem[ring_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ftps_pkg::ST_IDLE;
         fpt_ff         <= ftps_pkg::FPT_RESET;
         start_stamp_ff <= '0;
         ema_ff         <= '0;
         max_ff         <= '0;
         sum_ff         <= '0;
         stop_count_ff  <= '0;
         ring_pos_ff    <= '0;
         wrapped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid && csr_bus.ready) begin
            fpt_ff <= csr_bus.data;
         end
         if (req_xfer && req_bus.kind == ftps_pkg::KIND_START) begin
            start_stamp_ff <= req_bus.time_low;
         end
         if (finish_go) begin
            ema_ff <= ema_in;
            max_ff <= max_in;
            sum_ff <= sum_in;
            if (stop_count_ff <= ftps_pkg::WARMUP_STOPS) begin
               stop_count_ff <= stop_count_ff + 7'd1;
            end
            if (ring_pos_ff == POS_LAST) begin
               ring_pos_ff <= '0;
               wrapped_ff  <= 1'b1;
            end else begin
               ring_pos_ff <= ring_pos_ff + POS_W'(1);
            end
         end
         // hold the result until its transfer
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.last_frames = rsp_last_ff;
   assign rsp_bus.avg_frames  = rsp_avg_ff;
   assign rsp_bus.max_frames  = rsp_max_ff;
   assign rsp_bus.window_sum  = rsp_sum_ff;

`ifndef SYNTHESIS
   a_stop_starts_seq: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_bus.kind == ftps_pkg::KIND_STOP) |=> state_ff == ftps_pkg::ST_MUL_LO)
      else $error("stop transfer did not start the sequencer");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ftps_pkg::ST_FINISH && !out_free) |=> state_ff == ftps_pkg::ST_FINISH)
      else $error("result dropped while output register busy");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ftps_pkg::ST_FINISH))
      else $error("result raised outside finish step");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ring_pos_ff <= POS_LAST)
      else $error("ring position out of range");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      stop_count_ff <= ftps_pkg::WARMUP_STOPS + 7'd1)
      else $error("stop count passed saturation");

   a_ema_fits: assert property (@(posedge clock) disable iff (reset)
      finish_go |-> ema_sum[48] == 1'b0)
      else $error("average overflowed 32 bits");
`endif

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame time probe statistics testbench
// Sends start/stop probe events in bursts against a result sink that stalls.
// A scoreboard predicts the frames, the average, the maximum after warm-up
// and the window sum for every stop. Six frames_per_tick settings are used,
// from zero up to full scale.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int          WINDOW           = 100;
   localparam int          WARMUP           = 100;
   localparam logic [63:0] AVG_OLD_W        = 64'd62915;
   localparam logic [63:0] AVG_NEW_W        = 64'd2621;
   localparam logic [63:0] AVG_ROUND        = 64'd32768;
   localparam logic [47:0] RATE_AT_RESET    = 48'd416582966;
   localparam int          SETTLE_CYCLES    = 12;
   localparam int          CYCLE_LIMIT      = 500000;
   localparam int          RANDOM_PER_PHASE = 320;
   localparam int          PHASES           = 6;

   typedef struct packed {
      logic [ftps_pkg::FRAMES_W-1:0] last_frames;
      logic [ftps_pkg::FRAMES_W-1:0] avg_frames;
      logic [ftps_pkg::FRAMES_W-1:0] max_frames;
      logic [ftps_pkg::SUM_W-1:0]    window_sum;
   } frame_stats_type;

   class frame_stats_board;
      logic [ftps_pkg::FPT_W-1:0]    rate;
      logic [ftps_pkg::TIME_W-1:0]   stamp;
      logic [ftps_pkg::FRAMES_W-1:0] avg;
      logic [ftps_pkg::FRAMES_W-1:0] peak;
      logic [ftps_pkg::SUM_W-1:0]    ring_total;
      logic [ftps_pkg::FRAMES_W-1:0] history [WINDOW];
      int                            stops_seen;
      int                            slot;
      frame_stats_type               pending_stats [$];
      int                            errors;
      int                            checked;
      int                            full_scale;
      int                            events;
      int                            stop_events;

      function new();
         rate        = RATE_AT_RESET;
         stamp       = '0;
         avg         = '0;
         peak        = '0;
         ring_total  = '0;
         stops_seen  = 0;
         slot        = 0;
         errors      = 0;
         checked     = 0;
         full_scale  = 0;
         events      = 0;
         stop_events = 0;
         foreach (history[i]) history[i] = '0;
      endfunction

      function void set_rate(logic [ftps_pkg::FPT_W-1:0] value);
         rate = value;
      endfunction

      function int pending();
         return pending_stats.size();
      endfunction

      // Q32.0 ticks times Q16.32 rate, truncated to Q32.0 frames, saturated
      function logic [ftps_pkg::FRAMES_W-1:0] ticks_to_frames(
            logic [ftps_pkg::TIME_W-1:0] ticks);
         logic [63:0] whole;
         logic [63:0] part;
         whole = {32'd0, ticks} * {48'd0, rate[47:32]};
         part  = ({32'd0, ticks} * {32'd0, rate[31:0]}) >> 32;
         whole = whole + part;
         if (whole > 64'h0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
         return whole[31:0];
      endfunction

      function void note_event(logic kind, logic [ftps_pkg::TIME_W-1:0] when);
         logic [ftps_pkg::TIME_W-1:0]   elapsed;
         logic [ftps_pkg::FRAMES_W-1:0] frames;
         logic [63:0]                   acc;
         frame_stats_type               want;
         events++;
         if (kind == ftps_pkg::KIND_START) begin
            stamp = when;
            return;
         end
         stop_events++;
         elapsed = when - stamp;
         frames  = ticks_to_frames(elapsed);
         if (frames == 32'hFFFF_FFFF) full_scale++;
         // maximum counts only once warm-up is over, judged before this stop
         if (stops_seen > WARMUP && peak < frames) peak = frames;
         acc = {32'd0, avg} * AVG_OLD_W + {32'd0, frames} * AVG_NEW_W + AVG_ROUND;
         avg = acc[47:16];
         ring_total    = ring_total - {7'd0, history[slot]} + {7'd0, frames};
         history[slot] = frames;
         slot          = (slot == WINDOW - 1) ? 0 : slot + 1;
         if (stops_seen <= WARMUP) stops_seen++;
         want.last_frames = frames;
         want.avg_frames  = avg;
         want.max_frames  = peak;
         want.window_sum  = ring_total;
         pending_stats.push_back(want);
      endfunction

      function void check_result(frame_stats_type got);
         frame_stats_type want;
         if (pending_stats.size() == 0) begin
            $error("statistics transfer with no stop pending");
            errors++;
            return;
         end
         want = pending_stats.pop_front();
         checked++;
         if (got.last_frames !== want.last_frames) begin
            $error("last_frames: expected %h, got %h", want.last_frames, got.last_frames);
            errors++;
         end
         if (got.avg_frames !== want.avg_frames) begin
            $error("avg_frames: expected %h, got %h", want.avg_frames, got.avg_frames);
            errors++;
         end
         if (got.max_frames !== want.max_frames) begin
            $error("max_frames: expected %h, got %h", want.max_frames, got.max_frames);
            errors++;
         end
         if (got.window_sum !== want.window_sum) begin
            $error("window_sum: expected %h, got %h", want.window_sum, got.window_sum);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   int               cycle_count = 0;
   int               burst_left  = 0;
   frame_stats_board board;

   ftps_req_bus req_if ();
   ftps_rsp_bus rsp_if ();
   ftps_csr_bus csr_if ();

   frame_time_probe_stats u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("frame_time_probe_stats verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_result({rsp_if.last_frames, rsp_if.avg_frames,
                             rsp_if.max_frames, rsp_if.window_sum});
      end
   end

   // Result sink: runs of always-ready, coin-flip and periodic stall patterns
   initial begin
      int run;
      int mode;
      int period;
      rsp_if.ready = 1'b0;
      forever begin
         run    = $urandom_range(4, 60);
         mode   = $urandom_range(0, 3);
         period = $urandom_range(2, 6);
         for (int i = 0; i < run; i++) begin
            @(negedge clock);
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_if.ready <= (i % period == 0);
               default: rsp_if.ready <= (i % period != 0);
            endcase
         end
      end
   end

   task automatic send_event(input logic kind, input logic [ftps_pkg::TIME_W-1:0] when);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = $urandom_range(1, 15);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_if.kind     <= kind;
      req_if.time_low <= when;
      req_if.valid    <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      board.note_event(kind, when);
   endtask

   task automatic write_rate(input logic [ftps_pkg::FPT_W-1:0] value);
      @(negedge clock);
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      board.set_rate(value);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Drop valid, wait for every result, then let a trailing start finish
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ftps_pkg::TIME_W-1:0] pick_elapsed();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom_range(1, 256);
         2: return $urandom_range(65530, 65545);
         3, 4: return $urandom_range(1000, 1 << 24);
         5: return 32'hFFFF_FFFF - $urandom_range(0, 64);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_directed();
      send_event(ftps_pkg::KIND_STOP, 32'd5);   // stop before any start: stamp is zero
      send_event(ftps_pkg::KIND_STOP, 32'd0);
      send_event(ftps_pkg::KIND_START, 32'hFFFF_FFFF);
      send_event(ftps_pkg::KIND_STOP, 32'd0);   // timer wrap, one tick
      send_event(ftps_pkg::KIND_START, 32'd0);
      send_event(ftps_pkg::KIND_STOP, 32'hFFFF_FFFF);    // longest elapsed time
      send_event(ftps_pkg::KIND_STOP, 32'hFFFF_FFFF);    // stamp kept across stops
      send_event(ftps_pkg::KIND_START, 32'h8000_0000);
      send_event(ftps_pkg::KIND_STOP, 32'h7FFF_FFFF);
      send_event(ftps_pkg::KIND_START, 32'h5555_5555);
      send_event(ftps_pkg::KIND_START, 32'hAAAA_AAAA);   // second start replaces the stamp
      send_event(ftps_pkg::KIND_STOP, 32'hAAAA_AAAA + 32'd1_000_000);
      send_event(ftps_pkg::KIND_START, 32'h0001_2345);
      send_event(ftps_pkg::KIND_STOP, 32'h0001_2345 + 32'd65536);
      send_event(ftps_pkg::KIND_STOP, 32'h0001_2345 + 32'd65537);
      send_event(ftps_pkg::KIND_START, 32'hFFFF_0000);
      send_event(ftps_pkg::KIND_STOP, 32'h0000_FFFF);
   endtask

   // Mostly start/stop pairs; the rest are lone events and double starts
   task automatic run_random(input int count);
      int                          issued;
      int                          pick;
      logic [ftps_pkg::TIME_W-1:0] base;
      issued = 0;
      while (issued < count) begin
         pick = $urandom_range(0, 99);
         base = $urandom;
         if (pick < 70) begin
            send_event(ftps_pkg::KIND_START, base);
            send_event(ftps_pkg::KIND_STOP, base + pick_elapsed());
            issued += 2;
            if ($urandom_range(0, 3) == 0) begin
               send_event(ftps_pkg::KIND_STOP, base + pick_elapsed());
               issued++;
            end
         end else if (pick < 82) begin
            send_event(ftps_pkg::KIND_STOP, base);
            issued++;
         end else if (pick < 92) begin
            send_event(ftps_pkg::KIND_START, base);
            issued++;
         end else begin
            send_event(ftps_pkg::KIND_START, base);
            send_event(ftps_pkg::KIND_START, base + 32'd17);
            send_event(ftps_pkg::KIND_STOP, base + pick_elapsed());
            issued += 3;
         end
      end
   endtask

   initial begin
      logic [ftps_pkg::FPT_W-1:0] rate;
      board           = new();
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.kind     = ftps_pkg::KIND_START;
      req_if.time_low = '0;
      csr_if.valid    = 1'b0;
      csr_if.data     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset rate first, then a sweep that ends at full scale
      run_directed();
      run_random(RANDOM_PER_PHASE);
      settle();
      for (int p = 1; p < PHASES; p++) begin
         case (p)
            1: rate = '0;
            2: rate = {16'd0, $urandom};
            3: rate = 48'h0001_0000_0000;      // one frame per tick
            4: rate = 48'({$urandom, $urandom});
            default: rate = '1;
         endcase
         write_rate(rate);
         run_random(RANDOM_PER_PHASE);
         settle();
      end

      $display("Run covered %0d probe events (%0d stops) over %0d rate settings",
               board.events, board.stop_events, PHASES);
      $display("%0d statistics results checked, %0d at full-scale frames, %0d mismatches",
               board.checked, board.full_scale, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("frame_time_probe_stats verification clean");
      end else begin
         $display("frame_time_probe_stats verification failed");
      end
      $finish;
   end

endmodule
